@@ rtl/mst_pkg.sv @@
`default_nettype none
package mst_pkg;

   // default table depth
   localparam int ENTRIES_DEFAULT = 8;

   // fixed field widths
   localparam int PORT_W   = 16;
   localparam int PARAM_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 3;
   localparam int USED_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_FIND   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BUSY      = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // one stored session: key and both parameter words
   typedef struct packed {
      logic [PORT_W-1:0]  port;
      logic [PARAM_W-1:0] rx_param;
      logic [PARAM_W-1:0] tx_param;
   } word_type;

endpackage
`default_nettype wire

@@ rtl/mst_req_if.sv @@
`default_nettype none
interface mst_req_if;
   logic                         valid;
   logic                         ready;
   logic [mst_pkg::OP_W-1:0]     opcode;
   logic [mst_pkg::PORT_W-1:0]   port_id;
   logic                         direction;
   logic [mst_pkg::PARAM_W-1:0]  param_in;

   modport source (output valid, opcode, port_id, direction, param_in, input ready);
   modport sink   (input valid, opcode, port_id, direction, param_in, output ready);
endinterface
`default_nettype wire

@@ rtl/mst_rsp_if.sv @@
`default_nettype none
interface mst_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mst_pkg::STATUS_W-1:0]   status;
   logic                           found;
   logic [mst_pkg::SLOT_W-1:0]     slot_index;
   logic                           rx_active;
   logic                           tx_active;
   logic [mst_pkg::PARAM_W-1:0]    param_out;
   logic [mst_pkg::USED_W-1:0]     entries_used;

   modport source (output valid, status, found, slot_index, rx_active, tx_active,
                   param_out, entries_used, input ready);
   modport sink   (input valid, status, found, slot_index, rx_active, tx_active,
                   param_out, entries_used, output ready);
endinterface
`default_nettype wire

@@ rtl/mirror_session_table.sv @@
`default_nettype none
// Channel | Dir | Beat
// --------+-----+-----------------------------------------------------
// req_if  | in  | opcode, port_id, direction, param_in
// rsp_if  | out | status, found, slot_index, rx_active, tx_active,
//         |     | param_out, entries_used
//
// Each request passes through three steps: taking the beat, a sweep of the key
// store through its single read port, and an update of the table that loads
// the result register.
// Synchronous reset clears the valid and active marks and the entry count;
// stored keys and parameters need no clearing.
// A result waits in its register while the next request is taken; the update
// step stalls only when a previous result has not yet been taken.
module mirror_session_table #(
   parameter int ENTRIES = mst_pkg::ENTRIES_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   mst_req_if.sink    req_if,
   mst_rsp_if.source  rsp_if
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC
   } state_type;

   state_type state_ff;

   // captured request
   logic [mst_pkg::OP_W-1:0]    op_ff;
   logic [mst_pkg::PORT_W-1:0]  port_ff;
   logic                        dir_ff;
   logic [mst_pkg::PARAM_W-1:0] param_ff;

   // sweep progress
   logic [CNT_W-1:0] scan_ff;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;
   mst_pkg::word_type cap_ff;

   // per-entry marks and count
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] rxa_ff, rxa_in;
   logic [ENTRIES-1:0] txa_ff, txa_in;
   logic [CNT_W-1:0]   used_ff, used_in;

   // result register
   logic                           rsp_valid_ff;
   logic [mst_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic                           rsp_found_ff;
   logic [mst_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic                           rsp_rxa_ff;
   logic                           rsp_txa_ff;
   logic [mst_pkg::PARAM_W-1:0]    rsp_param_ff;
   logic [mst_pkg::USED_W-1:0]     rsp_used_ff;

   // store access
   logic [IDX_W-1:0]  rd_addr;
   mst_pkg::word_type rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   mst_pkg::word_type wr_data;

   // update step results
   mst_pkg::status_type         st;
   logic                        fnd;
   logic [IDX_W-1:0]            slot;
   logic                        rxa_o;
   logic                        txa_o;
   logic [mst_pkg::PARAM_W-1:0] pout;
   logic                        hit_rx;
   logic                        hit_tx;
   logic                        cmp_hit;
   logic                        out_free;
   logic                        req_beat;

   mst_store #(.ENTRIES(ENTRIES)) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_beat     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // sweep address and compare of the word read last cycle
   assign rd_addr = scan_ff[IDX_W-1:0];
   assign cmp_hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_data.port == port_ff);

   assign hit_rx = rxa_ff[hit_idx_ff];
   assign hit_tx = txa_ff[hit_idx_ff];

   // decide the update and the result from the sweep outcome
   always_comb begin
      st       = mst_pkg::ST_OK;
      fnd      = 1'b0;
      slot     = '0;
      rxa_o    = 1'b0;
      txa_o    = 1'b0;
      pout     = '0;
      valid_in = valid_ff;
      rxa_in   = rxa_ff;
      txa_in   = txa_ff;
      used_in  = used_ff;
      wr_en    = 1'b0;
      wr_addr  = hit_idx_ff;
      wr_data  = cap_ff;
      case (op_ff)
         mst_pkg::OP_ADD: begin
            if (hit_ff) begin
               slot = hit_idx_ff;
               fnd  = 1'b1;
               if (dir_ff ? hit_tx : hit_rx) begin
                  st    = mst_pkg::ST_BUSY;
                  rxa_o = hit_rx;
                  txa_o = hit_tx;
                  pout  = dir_ff ? cap_ff.tx_param : cap_ff.rx_param;
               end else begin
                  wr_en = 1'b1;
                  if (dir_ff) begin
                     wr_data.tx_param   = param_ff;
                     txa_in[hit_idx_ff] = 1'b1;
                  end else begin
                     wr_data.rx_param   = param_ff;
                     rxa_in[hit_idx_ff] = 1'b1;
                  end
                  rxa_o = hit_rx | !dir_ff;
                  txa_o = hit_tx | dir_ff;
                  pout  = param_ff;
               end
            end else if (free_ff) begin
               wr_en                = 1'b1;
               wr_addr              = free_idx_ff;
               wr_data.port         = port_ff;
               wr_data.rx_param     = param_ff;
               wr_data.tx_param     = param_ff;
               valid_in[free_idx_ff] = 1'b1;
               rxa_in[free_idx_ff]  = !dir_ff;
               txa_in[free_idx_ff]  = dir_ff;
               used_in              = used_ff + CNT_W'(1);
               fnd                  = 1'b1;
               slot                 = free_idx_ff;
               rxa_o                = !dir_ff;
               txa_o                = dir_ff;
               pout                 = param_ff;
            end else begin
               st = mst_pkg::ST_FULL;
            end
         end
         mst_pkg::OP_REMOVE: begin
            if (!hit_ff) begin
               st = mst_pkg::ST_NOT_FOUND;
            end else begin
               slot  = hit_idx_ff;
               wr_en = 1'b1;
               if (dir_ff) begin
                  wr_data.tx_param   = '0;
                  txa_in[hit_idx_ff] = 1'b0;
               end else begin
                  wr_data.rx_param   = '0;
                  rxa_in[hit_idx_ff] = 1'b0;
               end
               if (!(dir_ff ? hit_rx : hit_tx)) begin
                  // both directions idle: free the entry
                  valid_in[hit_idx_ff] = 1'b0;
                  if (used_ff != '0) begin
                     used_in = used_ff - CNT_W'(1);
                  end
               end else begin
                  fnd   = 1'b1;
                  rxa_o = dir_ff ? hit_rx : 1'b0;
                  txa_o = dir_ff ? 1'b0 : hit_tx;
               end
            end
         end
         default: begin
            // find, and the unused code served as find
            if (!hit_ff) begin
               st = mst_pkg::ST_NOT_FOUND;
            end else begin
               fnd   = 1'b1;
               slot  = hit_idx_ff;
               rxa_o = hit_rx;
               txa_o = hit_tx;
               if (dir_ff) begin
                  pout = hit_tx ? cap_ff.tx_param : '0;
               end else begin
                  pout = hit_rx ? cap_ff.rx_param : '0;
               end
            end
         end
      endcase
      if (!(state_ff == S_EXEC && out_free)) begin
         wr_en = 1'b0;
      end
   end

   // sequencer, table marks and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rxa_ff       <= '0;
         txa_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         // drop a taken result unless the update step reloads the register
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_EXEC) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  op_ff      <= req_if.opcode;
                  port_ff    <= req_if.port_id;
                  dir_ff     <= req_if.direction;
                  param_ff   <= req_if.param_in;
                  scan_ff    <= '0;
                  cmp_vld_ff <= 1'b0;
                  hit_ff     <= 1'b0;
                  free_ff    <= 1'b0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               // advance the read address, compare the returning word
               cmp_vld_ff <= (scan_ff < CNT_W'(ENTRIES));
               cmp_idx_ff <= scan_ff[IDX_W-1:0];
               if (scan_ff < CNT_W'(ENTRIES)) begin
                  scan_ff <= scan_ff + CNT_W'(1);
               end
               if (cmp_hit && !hit_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= cmp_idx_ff;
                  cap_ff     <= rd_data;
               end
               if (cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
               if (scan_ff == CNT_W'(ENTRIES)) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               // hold until the result register is free
               if (out_free) begin
                  valid_ff      <= valid_in;
                  rxa_ff        <= rxa_in;
                  txa_ff        <= txa_in;
                  used_ff       <= used_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st;
                  rsp_found_ff  <= fnd;
                  rsp_slot_ff   <= mst_pkg::SLOT_W'(slot);
                  rsp_rxa_ff    <= rxa_o;
                  rsp_txa_ff    <= txa_o;
                  rsp_param_ff  <= pout;
                  rsp_used_ff   <= mst_pkg::USED_W'(used_in);
                  cmp_vld_ff    <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.found        = rsp_found_ff;
   assign rsp_if.slot_index   = rsp_slot_ff;
   assign rsp_if.rx_active    = rsp_rxa_ff;
   assign rsp_if.tx_active    = rsp_txa_ff;
   assign rsp_if.param_out    = rsp_param_ff;
   assign rsp_if.entries_used = rsp_used_ff;

   // entry count tracks the valid marks
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) == $countones(valid_ff))
      else $error("entry count differs from valid marks");

   // an active direction belongs to a valid entry
   a_active_valid: assert property (@(posedge clock) disable iff (reset)
      ((rxa_ff | txa_ff) & ~valid_ff) == '0)
      else $error("active slot on a free entry");

   // a taken request blocks the next one
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_if.ready)
      else $error("request taken while a request is in progress");

   // a sweep hit points at a valid entry
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && hit_ff) |-> valid_ff[hit_idx_ff])
      else $error("sweep hit on a free entry");

endmodule
`default_nettype wire

@@ rtl/mst_store.sv @@
`default_nettype none
module mst_store #(
   parameter int ENTRIES = mst_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic              clock,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output mst_pkg::word_type      rd_data,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire mst_pkg::word_type wr_data
);

   mst_pkg::word_type mem [ENTRIES];
   mst_pkg::word_type rd_data_ff;

   // write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ verif/mirror_session_table_tb.sv @@
`timescale 1ns / 1ps

module mirror_session_table_tb;
   import mst_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS = 1026;
   localparam int HOLD_AT      = 800;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int POOL_SIZE    = 12;

   // opcode value outside the defined set, served as a find
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]    opcode;
      logic [PORT_W-1:0]  port;
      logic               dir;
      logic [PARAM_W-1:0] param;
   } session_req_t;

   typedef struct {
      status_type         status;
      logic               found;
      logic [SLOT_W-1:0]  slot;
      logic               rx_on;
      logic               tx_on;
      logic [PARAM_W-1:0] param;
      logic [USED_W-1:0]  used;
   } session_reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mst_req_if req_bus ();
   mst_rsp_if rsp_bus ();

   mirror_session_table #(.ENTRIES(ENTRIES)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // shadow copy of the session table
   logic               tbl_valid [ENTRIES] = '{default: 1'b0};
   logic [PORT_W-1:0]  tbl_port  [ENTRIES] = '{default: '0};
   logic               rx_on     [ENTRIES] = '{default: 1'b0};
   logic               tx_on     [ENTRIES] = '{default: 1'b0};
   logic [PARAM_W-1:0] rx_word   [ENTRIES] = '{default: '0};
   logic [PARAM_W-1:0] tx_word   [ENTRIES] = '{default: '0};
   int                 used_entries = 0;

   session_req_t   pending_requests [$];
   session_reply_t replies_due [$];

   int   total_items = 0;
   int   beats_in = 0;
   int   failures = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   logic req_beat = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one request to the shadow table and build the reply it earns
   function automatic session_reply_t apply_session_request(session_req_t r);
      session_reply_t rep;
      int hit;
      int free_slot;
      int shown;
      hit = -1;
      free_slot = -1;
      for (int k = 0; k < ENTRIES; k++) begin
         if (hit < 0 && tbl_valid[k] && tbl_port[k] == r.port) hit = k;
         if (free_slot < 0 && !tbl_valid[k]) free_slot = k;
      end
      shown = hit;
      rep.status = ST_OK;
      rep.found = 1'b0;
      rep.slot = '0;
      rep.rx_on = 1'b0;
      rep.tx_on = 1'b0;
      rep.param = '0;

      if (r.opcode == OP_ADD) begin
         if (hit >= 0) begin
            if (r.dir ? tx_on[hit] : rx_on[hit]) begin
               rep.status = ST_BUSY;
            end else if (r.dir) begin
               tx_on[hit] = 1'b1;
               tx_word[hit] = r.param;
            end else begin
               rx_on[hit] = 1'b1;
               rx_word[hit] = r.param;
            end
         end else if (free_slot < 0) begin
            rep.status = ST_FULL;
         end else begin
            // new session: the other direction starts idle
            tbl_valid[free_slot] = 1'b1;
            tbl_port[free_slot] = r.port;
            rx_on[free_slot] = !r.dir;
            tx_on[free_slot] = r.dir;
            if (r.dir) tx_word[free_slot] = r.param;
            else rx_word[free_slot] = r.param;
            used_entries++;
            shown = free_slot;
         end
      end else if (r.opcode == OP_REMOVE) begin
         if (hit < 0) begin
            rep.status = ST_NOT_FOUND;
         end else begin
            if (r.dir) begin
               tx_on[hit] = 1'b0;
               tx_word[hit] = '0;
            end else begin
               rx_on[hit] = 1'b0;
               rx_word[hit] = '0;
            end
            // free the entry once both directions are idle
            if (!rx_on[hit] && !tx_on[hit]) begin
               tbl_valid[hit] = 1'b0;
               if (used_entries > 0) used_entries--;
            end
         end
      end else if (hit < 0) begin
         rep.status = ST_NOT_FOUND;
      end

      if (shown >= 0) begin
         rep.slot = shown[SLOT_W-1:0];
         if (tbl_valid[shown]) begin
            rep.found = 1'b1;
            rep.rx_on = rx_on[shown];
            rep.tx_on = tx_on[shown];
            if (r.dir && tx_on[shown]) rep.param = tx_word[shown];
            if (!r.dir && rx_on[shown]) rep.param = rx_word[shown];
         end
      end
      rep.used = used_entries[USED_W-1:0];
      return rep;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic enqueue_request(logic [OP_W-1:0] op, logic [PORT_W-1:0] port, logic dir,
                                  logic [PARAM_W-1:0] param);
      session_req_t r;
      r.opcode = op;
      r.port = port;
      r.dir = dir;
      r.param = param;
      pending_requests.push_back(r);
      total_items++;
   endtask

   // idle rates per phase: sender-light, then receiver-light, then none
   function automatic int sender_idle_pct();
      if (beats_in < total_items / 3) return 37;
      else if (beats_in < 2 * total_items / 3) return 70;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (beats_in < total_items / 3) return 70;
      else if (beats_in < 2 * total_items / 3) return 37;
      return 0;
   endfunction

   // drive request beats from the pending queue
   always @(negedge clock) begin
      session_req_t nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_beat) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
            nxt = pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.opcode <= nxt.opcode;
            req_bus.port_id <= nxt.port;
            req_bus.direction <= nxt.dir;
            req_bus.param_in <= nxt.param;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // drive response ready; hold low during the long stall
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && hold_left == 0 && $urandom_range(99) >= receiver_idle_pct();
   end

   // count down one long receiver stall while requests keep coming
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // predict on each request beat, check each response beat
   always @(posedge clock) begin
      session_req_t   taken;
      session_reply_t want;
      req_beat <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken.opcode = req_bus.opcode;
            taken.port = req_bus.port_id;
            taken.dir = req_bus.direction;
            taken.param = req_bus.param_in;
            replies_due.push_back(apply_session_request(taken));
            beats_in <= beats_in + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (replies_due.size() == 0) begin
               $error("response beat with no request outstanding");
               failures++;
            end else begin
               want = replies_due.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_bus.status));
               compare_field("found", 32'(want.found), 32'(rsp_bus.found));
               compare_field("slot_index", 32'(want.slot), 32'(rsp_bus.slot_index));
               compare_field("rx_active", 32'(want.rx_on), 32'(rsp_bus.rx_active));
               compare_field("tx_active", 32'(want.tx_on), 32'(rsp_bus.tx_active));
               compare_field("param_out", want.param, rsp_bus.param_out);
               compare_field("entries_used", 32'(want.used), 32'(rsp_bus.entries_used));
            end
         end
      end
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [PORT_W-1:0] port_pool [POOL_SIZE];
      logic [PORT_W-1:0] port;
      logic [OP_W-1:0]   op;
      logic [PARAM_W-1:0] param;
      int pick;

      req_bus.valid = 1'b0;
      req_bus.opcode = OP_FIND;
      req_bus.port_id = '0;
      req_bus.direction = 1'b0;
      req_bus.param_in = '0;
      rsp_bus.ready = 1'b0;

      // empty table, then a single port through both directions
      enqueue_request(OP_FIND, 16'h1234, 1'b0, 32'h0);
      enqueue_request(OP_REMOVE, 16'h1234, 1'b1, 32'h0);
      enqueue_request(OP_ADD, 16'h0000, 1'b0, 32'hFFFF_FFFF);
      enqueue_request(OP_ADD, 16'h0000, 1'b1, 32'h0000_0000);
      enqueue_request(OP_ADD, 16'h0000, 1'b0, 32'h5A5A_5A5A);
      enqueue_request(OP_FIND, 16'h0000, 1'b1, 32'h0);
      enqueue_request(OP_UNUSED, 16'h0000, 1'b0, 32'h0);
      enqueue_request(OP_REMOVE, 16'h0000, 1'b1, 32'h0);
      enqueue_request(OP_REMOVE, 16'h0000, 1'b1, 32'h0);
      enqueue_request(OP_REMOVE, 16'h0000, 1'b0, 32'h0);
      enqueue_request(OP_FIND, 16'h0000, 1'b0, 32'h0);

      // fill every entry, then overflow
      enqueue_request(OP_ADD, 16'hFFFF, 1'b0, 32'h8000_0001);
      enqueue_request(OP_ADD, 16'h8000, 1'b1, 32'h7FFF_FFFE);
      enqueue_request(OP_ADD, 16'h0001, 1'b0, 32'h0000_0001);
      enqueue_request(OP_ADD, 16'h0002, 1'b1, 32'h0000_0002);
      enqueue_request(OP_ADD, 16'h0004, 1'b0, 32'h0000_0004);
      enqueue_request(OP_ADD, 16'h0008, 1'b1, 32'h0000_0008);
      enqueue_request(OP_ADD, 16'h0010, 1'b0, 32'h0000_0010);
      enqueue_request(OP_ADD, 16'h0020, 1'b1, 32'h0000_0020);
      enqueue_request(OP_ADD, 16'h7FFF, 1'b0, 32'hDEAD_BEEF);
      enqueue_request(OP_ADD, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      enqueue_request(OP_REMOVE, 16'h8000, 1'b1, 32'h0);
      enqueue_request(OP_ADD, 16'h7FFF, 1'b1, 32'hC0DE_0001);
      enqueue_request(OP_FIND, 16'hFFFF, 1'b1, 32'h0);
      enqueue_request(OP_REMOVE, 16'h0001, 1'b1, 32'h0);

      // random traffic over a small port pool so the table churns
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hFFFF;
      for (int k = 2; k < POOL_SIZE; k++) port_pool[k] = PORT_W'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) op = OP_ADD;
         else if (pick < 75) op = OP_REMOVE;
         else if (pick < 95) op = OP_FIND;
         else op = OP_UNUSED;
         if ($urandom_range(9) == 0) port = PORT_W'($urandom);
         else port = port_pool[$urandom_range(POOL_SIZE - 1)];
         pick = $urandom_range(19);
         if (pick == 0) param = '0;
         else if (pick == 1) param = '1;
         else param = $urandom;
         enqueue_request(op, port, 1'($urandom_range(1)), param);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: all requests taken, all replies seen, then settle
      while (beats_in < total_items) @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4 * ENTRIES) @(posedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
